// ===== rtl/rrprng_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rrprng_pkg
// Shared constants, types and the rotate function of the lagged rotate generator.
// ----------------------------------------------------------------------------
package rrprng_pkg;

  localparam int WORD_W        = 32;
  localparam int SEED_IDX_W    = 6;
  localparam int LONG_LAG_DEF  = 57;
  localparam int SHORT_LAG_DEF = 13;
  localparam int ROT_SELF      = 9;
  localparam int ROT_PARTNER   = 13;

  // item kinds carried on in_tuser
  localparam logic CMD_SEED = 1'b0;
  localparam logic CMD_DRAW = 1'b1;

  // controller to datapath
  typedef struct packed {
    logic seed_wr;   // write seed word, clear read position
    logic rd_draw;   // read word below read position, step position down
    logic rf_start;  // zero the refill index
    logic rf_rd;     // read entry and its partner
    logic rf_wr;     // write refilled entry, advance index
    logic pos_load;  // set read position to the buffer length
    logic out_load;  // capture read word into the output register
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic pos_zero;
    logic rf_last;
    logic out_full;
  } stat_t;

  function automatic logic [WORD_W-1:0] rotl(input logic [WORD_W-1:0] v,
                                              input int unsigned r);
    logic [2*WORD_W-1:0] d;
    d = {v, v} << r;
    return d[2*WORD_W-1:WORD_W];
  endfunction

endpackage
`default_nettype wire

// ===== rtl/rrprng_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rrprng_ram
// Generic RAM: one write port, two read ports, registered read data.
// ----------------------------------------------------------------------------
module rrprng_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 57
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr_a,
  output      logic [WIDTH-1:0]         rd_data_a,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr_b,
  output      logic [WIDTH-1:0]         rd_data_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_a <= mem[rd_addr_a];
    rd_data_b <= mem[rd_addr_b];
  end

endmodule
`default_nettype wire

// ===== rtl/rrprng_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rrprng_ctrl
// Sequencer: seeds, draws and the per-entry read-then-write buffer refill.
// ----------------------------------------------------------------------------
module rrprng_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_tvalid,
  output      logic               in_tready,
  input  wire logic               in_cmd,
  input  wire logic               out_tready,
  input  wire rrprng_pkg::stat_t  stat,
  output      rrprng_pkg::cmd_t   cmd
);

  typedef enum logic [4:0] {
    S_IDLE     = 5'b00001,
    S_RF_RD    = 5'b00010,
    S_RF_WR    = 5'b00100,
    S_DRAW_RD  = 5'b01000,
    S_DRAW_OUT = 5'b10000
  } state_t;

  state_t state_r, state_nxt;
  logic   accept;

  assign in_tready = (state_r == S_IDLE);
  assign accept    = in_tvalid & in_tready;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_cmd == rrprng_pkg::CMD_SEED) begin
            cmd.seed_wr = 1'b1;
          end else if (stat.pos_zero) begin
            cmd.rf_start = 1'b1;
            state_nxt    = S_RF_RD;
          end else begin
            cmd.rd_draw = 1'b1;
            state_nxt   = S_DRAW_OUT;
          end
        end
      end
      S_RF_RD: begin
        cmd.rf_rd = 1'b1;
        state_nxt = S_RF_WR;
      end
      S_RF_WR: begin
        cmd.rf_wr = 1'b1;
        if (stat.rf_last) begin
          cmd.pos_load = 1'b1;
          state_nxt    = S_DRAW_RD;
        end else begin
          state_nxt = S_RF_RD;
        end
      end
      S_DRAW_RD: begin
        cmd.rd_draw = 1'b1;
        state_nxt   = S_DRAW_OUT;
      end
      S_DRAW_OUT: begin
        // hold until the output register is free or being drained
        if (!stat.out_full || out_tready) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/rrprng_dpath.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rrprng_dpath
// Lag buffer, read position, refill index, valid bits and output register.
// ----------------------------------------------------------------------------
module rrprng_dpath #(
  parameter int LONG_LAG  = rrprng_pkg::LONG_LAG_DEF,
  parameter int SHORT_LAG = rrprng_pkg::SHORT_LAG_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire rrprng_pkg::cmd_t                    cmd,
  output      rrprng_pkg::stat_t                   stat,
  input  wire logic [rrprng_pkg::SEED_IDX_W-1:0]   seed_index,
  input  wire logic [rrprng_pkg::WORD_W-1:0]       seed_word,
  input  wire logic                                out_tready,
  output      logic                                out_tvalid,
  output      logic [rrprng_pkg::WORD_W-1:0]       out_word
);

  localparam int AW = $clog2(LONG_LAG);
  localparam int PW = $clog2(LONG_LAG + 1);
  localparam int SL = (SHORT_LAG < LONG_LAG) ? SHORT_LAG : LONG_LAG - 1;
  localparam int DL = LONG_LAG - SL;

  logic [PW-1:0]                  pos_r, pos_nxt, pos_m1;
  logic [AW-1:0]                  rf_idx_r, rf_idx_nxt, partner;
  logic [LONG_LAG-1:0]            vld_r, vld_nxt;
  logic                           vld_a_r, vld_b_r;
  logic [rrprng_pkg::WORD_W-1:0]  out_word_r;
  logic                           out_valid_r, out_valid_nxt;

  logic                           wr_en;
  logic [AW-1:0]                  wr_addr, rd_addr_a;
  logic [rrprng_pkg::WORD_W-1:0]  wr_data, rd_a, rd_b, word_a, word_b, mixed;
  logic                           seed_in_range;

  assign pos_m1        = pos_r - PW'(1);
  assign seed_in_range = (32'(seed_index) < LONG_LAG);
  assign partner       = (32'(rf_idx_r) < SL) ? rf_idx_r + AW'(DL) : rf_idx_r - AW'(SL);
  // outside a refill or a draw read, keep reading the word last drawn so a
  // stalled output load still sees it
  assign rd_addr_a     = cmd.rf_rd   ? rf_idx_r :
                         cmd.rd_draw ? pos_m1[AW-1:0] : pos_r[AW-1:0];

  // an entry never written since reset reads as zero
  assign word_a = vld_a_r ? rd_a : '0;
  assign word_b = vld_b_r ? rd_b : '0;
  assign mixed  = rrprng_pkg::rotl(word_a, rrprng_pkg::ROT_SELF)
                + rrprng_pkg::rotl(word_b, rrprng_pkg::ROT_PARTNER);

  assign wr_en   = (cmd.seed_wr & seed_in_range) | cmd.rf_wr;
  assign wr_addr = cmd.rf_wr ? rf_idx_r : AW'(seed_index);
  assign wr_data = cmd.rf_wr ? mixed : seed_word;

  rrprng_ram #(
    .WIDTH (rrprng_pkg::WORD_W),
    .DEPTH (LONG_LAG)
  ) u_buf (
    .clk       (clk),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_addr_a (rd_addr_a),
    .rd_data_a (rd_a),
    .rd_addr_b (partner),
    .rd_data_b (rd_b)
  );

  always_comb begin
    pos_nxt       = pos_r;
    rf_idx_nxt    = rf_idx_r;
    vld_nxt       = vld_r;
    out_valid_nxt = out_valid_r;
    if (cmd.seed_wr) begin
      pos_nxt = '0;
    end
    if (cmd.rd_draw) begin
      pos_nxt = pos_m1;
    end
    if (cmd.pos_load) begin
      pos_nxt = PW'(LONG_LAG);
    end
    if (cmd.rf_start) begin
      rf_idx_nxt = '0;
    end
    if (cmd.rf_wr) begin
      rf_idx_nxt = rf_idx_r + AW'(1);
    end
    if (wr_en) begin
      vld_nxt[wr_addr] = 1'b1;
    end
    if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= '0;
      rf_idx_r    <= '0;
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      pos_r       <= pos_nxt;
      rf_idx_r    <= rf_idx_nxt;
      vld_r       <= vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    vld_a_r <= vld_r[rd_addr_a];
    vld_b_r <= vld_r[partner];
    if (cmd.out_load) begin
      out_word_r <= word_a;
    end
  end

  assign stat.pos_zero = (pos_r == '0);
  assign stat.rf_last  = (rf_idx_r == AW'(LONG_LAG - 1));
  assign stat.out_full = out_valid_r;
  assign out_tvalid    = out_valid_r;
  assign out_word      = out_word_r;

endmodule
`default_nettype wire

// ===== rtl/ranrot_lagged_rotate_prng_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ranrot_lagged_rotate_prng_core
// RANROT 32-bit lagged rotate generator with a RAM lag buffer.
// ----------------------------------------------------------------------------
//  channel | direction | tdata (low bit up)              | tuser
//  --------+-----------+---------------------------------+-------------------
//  in_     | slave     | seed_index[5:0], seed_word[37:6] | cmd (0 seed, 1 draw)
//  out_    | master    | random_word[31:0]               | -
//
//  A seed word gives no result; it also drops the read position so the next
//  draw refills. A draw reads, then loads the output register. A refill runs
//  before every LONG_LAG-th draw: each entry and its partner are read on the
//  two RAM read ports, and the entry is written back in the next cycle, since
//  the upper entries depend on freshly written partners. Reset clears the
//  valid bits of the buffer at once, so unwritten entries read as zero and no
//  clearing pass runs. A full output register stalls a draw only at its output
//  load.
// ----------------------------------------------------------------------------
module ranrot_lagged_rotate_prng_core #(
  parameter int LONG_LAG  = rrprng_pkg::LONG_LAG_DEF,
  parameter int SHORT_LAG = rrprng_pkg::SHORT_LAG_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output      logic        in_tready,
  input  wire logic [39:0] in_tdata,   // seed_index[5:0], seed_word[37:6], zero pad
  input  wire logic        in_tuser,   // cmd
  output      logic        out_tvalid,
  input  wire logic        out_tready,
  output      logic [31:0] out_tdata   // random_word[31:0]
);

  rrprng_pkg::cmd_t  cmd;
  rrprng_pkg::stat_t stat;

  rrprng_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_cmd     (in_tuser),
    .out_tready (out_tready),
    .stat       (stat),
    .cmd        (cmd)
  );

  rrprng_dpath #(
    .LONG_LAG  (LONG_LAG),
    .SHORT_LAG (SHORT_LAG)
  ) u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .seed_index (in_tdata[5:0]),
    .seed_word  (in_tdata[37:6]),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_word   (out_tdata)
  );

endmodule
`default_nettype wire
